// File: rtl/tsw_pkg.sv
// Shared types, codes and constants of the TCP sender window/retransmit block.
package tsw_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_SEGS        = 16;
    localparam logic [16:0] FLIGHT_MAX = 17'h1FFFF;

    localparam logic [31:0] ISN_RST = 32'd0;
    localparam logic [15:0] ITO_RST = 16'd1000;
    localparam logic [10:0] MSS_RST = 11'd1000;

    typedef enum logic [1:0] {
        CFG_ISN = 2'd0,
        CFG_ITO = 2'd1,
        CFG_MSS = 2'd2,
        CFG_NONE = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FN_FILL  = 2'd0,
        FN_ACK   = 2'd1,
        FN_TICK  = 2'd2,
        FN_EMPTY = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KD_NEW    = 2'd0,
        KD_RETX   = 2'd1,
        KD_EMPTY  = 2'd2,
        KD_STATUS = 2'd3
    } t_kind;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [63:0] sum;
        logic        borrow;
    } t_alu_rsp;

    typedef struct packed {
        logic [63:0] start;
        logic [10:0] len;
        logic [1:0]  flags;
    } t_desc;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] seqno;
        logic [10:0] len;
        logic        syn;
        logic        fin;
        logic        acc;
        logic [16:0] flight;
        logic [7:0]  retry;
        logic        last;
    } t_result;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_F_ENTRY,
        ST_F_DIFF,
        ST_F_DEC,
        ST_SEND_WRAP,
        ST_SEND_EMIT,
        ST_A_OFF,
        ST_A_UNWRAP,
        ST_A_ADJ,
        ST_A_RANGE,
        ST_A_NEW,
        ST_P_READ,
        ST_P_END,
        ST_P_CMP,
        ST_A_TAIL,
        ST_T_ADD,
        ST_T_CMP,
        ST_T_WRAP,
        ST_T_EMIT,
        ST_E_WRAP,
        ST_E_EMIT,
        ST_S_WRAP,
        ST_STATUS
    } t_state;

endpackage

// File: rtl/tsw_if.sv
// Valid/ready channel interfaces: event input, result output, register write.
interface tsw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        open_request;
    logic [31:0] ack_number;
    logic [15:0] peer_window;
    logic [15:0] elapsed_ms;
    logic [15:0] bytes_buffered;
    logic        input_ended;
    modport source(output valid, func, open_request, ack_number, peer_window,
                   elapsed_ms, bytes_buffered, input_ended, input ready);
    modport sink(input valid, func, open_request, ack_number, peer_window,
                 elapsed_ms, bytes_buffered, input_ended, output ready);
endinterface

interface tsw_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] segment_seqno;
    logic [10:0] payload_length;
    logic        syn_flag;
    logic        fin_flag;
    logic        ack_accepted;
    logic [16:0] in_flight;
    logic [7:0]  retry_count;
    logic        last_item;
    modport source(output valid, kind, segment_seqno, payload_length, syn_flag,
                   fin_flag, ack_accepted, in_flight, retry_count, last_item,
                   input ready);
    modport sink(input valid, kind, segment_seqno, payload_length, syn_flag,
                 fin_flag, ack_accepted, in_flight, retry_count, last_item,
                 output ready);
endinterface

interface tsw_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [31:0] data;
    modport source(output valid, addr, data, input ready);
    modport sink(input valid, addr, data, output ready);
endinterface

// File: rtl/tsw_alu.sv
// Shared 64-bit add/subtract unit; borrow doubles as the less-than compare.
module tsw_alu import tsw_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);
    logic        sub;
    logic [63:0] b_op;
    logic [64:0] res;

    assign sub  = (i_req.op == ALU_SUB);
    assign b_op = sub ? ~i_req.b : i_req.b;
    assign res  = {1'b0, i_req.a} + {1'b0, b_op} + {64'd0, sub};

    assign o_rsp.sum    = res[63:0];
    assign o_rsp.borrow = sub & ~res[64];
endmodule

// File: rtl/tsw_queue.sv
// Ring store of outstanding segment descriptors, one write and one registered read.
module tsw_queue import tsw_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_desc         i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_desc         o_rd_data
);
    t_desc r_mem [DEPTH];
    t_desc r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;
endmodule

// File: rtl/tcp_sender_window_retransmit.sv
// TCP sender sequence-space control: sequencer around one shared 64-bit adder.
// Every request ends in a status item. An empty request first emits an empty item; a tick
// stops at a stopped or unexpired timer or retransmits the head segment; a fill emits
// segments while they fit; an ack is refused, found old, or retires acked heads and fills.
// Requests are taken only when idle; each emitted result waits for a free output slot.
// Synchronous active-low reset clears control state and restores register defaults.
module tcp_sender_window_retransmit import tsw_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsw_in_if.sink     i_in,
    tsw_out_if.source  o_out,
    tsw_cfg_if.sink    i_cfg
);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_state r_state, n_state;

    logic [31:0] r_isn;
    logic [15:0] r_ito;
    logic [10:0] r_mss;

    logic [63:0] r_next, n_next, r_acked, n_acked;
    logic [15:0] r_wnd, n_wnd;
    logic [16:0] r_flight, n_flight;
    logic        r_syn, n_syn, r_fin, n_fin, r_tact, n_tact;
    logic [31:0] r_tms, n_tms, r_cur, n_cur;
    logic [7:0]  r_retry, n_retry;
    logic [QW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [4:0]  r_nseg, n_nseg;

    logic        r_open, n_open, r_ended, n_ended;
    logic [31:0] r_ack, n_ack;
    logic [15:0] r_pwin, n_pwin, r_elap, n_elap, r_buf, n_buf;

    logic [63:0] r_abs, n_abs, r_tmp, n_tmp;
    logic        r_dec, n_dec, r_inc, n_inc;
    logic [31:0] r_seq, n_seq;
    logic [10:0] r_slen, n_slen;
    logic [1:0]  r_sflg, n_sflg;
    logic        r_stop, n_stop, r_from_ack, n_from_ack, r_first, n_first;
    logic        r_accept, n_accept;

    logic        r_ov, n_ov;
    t_result     r_o, n_o;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    logic          wr_en, rd_en;
    logic [QW-1:0] wr_addr;
    t_desc         wr_data, q_rd;

    tsw_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    tsw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (q_rd)
    );

    // Decisions shared by the sequencer and the datapath
    logic        in_fire, ofree;
    logic [16:0] window, room;
    logic [10:0] mss, size, take;
    logic [15:0] buf_left;
    logic        inwin, can_send, fin_case, data_ok, dfin;
    logic [CW:0] slot_sum;
    logic [QW-1:0] slot, head_inc;
    logic [11:0] send_seqlen, q_seqlen;
    logic [17:0] flight_add;
    logic        ack_gt, fire;

    assign in_fire  = i_in.valid && i_in.ready;
    assign ofree    = !r_ov || o_out.ready;
    assign window   = (r_wnd == 16'd0) ? 17'd1 : {1'b0, r_wnd};
    assign inwin    = (r_tmp[63:17] == '0) && (r_tmp[16:0] < window);
    assign can_send = (r_count < CW'(QUEUE_DEPTH)) && (r_nseg < 5'(MAX_SEGS));
    assign mss      = (r_mss == 11'd0) ? 11'd1 : r_mss;
    assign room     = window - r_tmp[16:0];
    assign size     = (room < {6'd0, mss}) ? room[10:0] : mss;
    assign take     = ({5'd0, size} < r_buf) ? size : r_buf[10:0];
    assign buf_left = r_buf - {5'd0, take};
    assign dfin     = r_ended && (buf_left == 16'd0) && ({6'd0, take} < window);
    assign fin_case = r_first && r_ended && (r_buf == 16'd0) && inwin;
    assign data_ok  = (r_buf != 16'd0) && inwin && can_send;

    assign slot_sum = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign slot     = (slot_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                      QW'(slot_sum - (CW+1)'(QUEUE_DEPTH)) : QW'(slot_sum);
    assign head_inc = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    assign send_seqlen = {1'b0, r_slen} + {11'd0, r_sflg[0]} + {11'd0, r_sflg[1]};
    assign q_seqlen    = {1'b0, q_rd.len} + {11'd0, q_rd.flags[0]} + {11'd0, q_rd.flags[1]};
    assign flight_add  = {1'b0, r_flight} + {6'd0, send_seqlen};
    assign ack_gt      = !alu_rsp.borrow && (alu_rsp.sum != 64'd0);
    assign fire        = !alu_rsp.borrow && (r_count != '0);

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // Operand selection for the shared adder
    always_comb begin
        alu_req.op = ALU_ADD;
        alu_req.a  = r_next;
        alu_req.b  = {32'd0, r_isn};
        case (r_state)
            ST_F_DIFF: begin
                alu_req.op = ALU_SUB;
                alu_req.b  = r_acked;
            end
            ST_SEND_EMIT: begin
                alu_req.b = {52'd0, send_seqlen};
            end
            ST_A_OFF: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {32'd0, r_ack};
            end
            ST_A_UNWRAP, ST_A_NEW: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = r_abs;
                alu_req.b  = r_acked;
            end
            ST_A_ADJ: begin
                alu_req.op = r_dec ? ALU_SUB : ALU_ADD;
                alu_req.a  = r_abs;
                alu_req.b  = 64'h1_0000_0000;
            end
            ST_A_RANGE: begin
                alu_req.op = ALU_SUB;
                alu_req.b  = r_abs;
            end
            ST_P_END: begin
                alu_req.a = q_rd.start;
                alu_req.b = {52'd0, q_seqlen};
            end
            ST_P_CMP: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = r_abs;
                alu_req.b  = r_tmp;
            end
            ST_T_ADD: begin
                alu_req.a = {32'd0, r_tms};
                alu_req.b = {48'd0, r_elap};
            end
            ST_T_CMP: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {32'd0, r_tms};
                alu_req.b  = {32'd0, r_cur};
            end
            ST_T_WRAP: begin
                alu_req.a = q_rd.start;
            end
            default: begin
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (t_func'(i_in.func))
                        FN_FILL: n_state = ST_F_ENTRY;
                        FN_ACK:  n_state = ST_A_OFF;
                        FN_TICK: n_state = ST_T_ADD;
                        default: n_state = ST_E_WRAP;
                    endcase
                end
            end
            ST_F_ENTRY: begin
                if (r_fin || (!r_syn && !(r_open && can_send))) begin
                    n_state = r_from_ack ? ST_A_TAIL : ST_S_WRAP;
                end else if (!r_syn) begin
                    n_state = ST_SEND_WRAP;
                end else begin
                    n_state = ST_F_DIFF;
                end
            end
            ST_F_DIFF: n_state = ST_F_DEC;
            ST_F_DEC: begin
                if ((fin_case && can_send) || (!fin_case && data_ok)) begin
                    n_state = ST_SEND_WRAP;
                end else begin
                    n_state = r_from_ack ? ST_A_TAIL : ST_S_WRAP;
                end
            end
            ST_SEND_WRAP: n_state = ST_SEND_EMIT;
            ST_SEND_EMIT: begin
                if (ofree) begin
                    if (r_stop) begin
                        n_state = r_from_ack ? ST_A_TAIL : ST_S_WRAP;
                    end else begin
                        n_state = ST_F_DIFF;
                    end
                end
            end
            ST_A_OFF:    n_state = ST_A_UNWRAP;
            ST_A_UNWRAP: n_state = ST_A_ADJ;
            ST_A_ADJ:    n_state = ST_A_RANGE;
            ST_A_RANGE:  n_state = alu_rsp.borrow ? ST_S_WRAP : ST_A_NEW;
            ST_A_NEW:    n_state = ack_gt ? ST_P_READ : ST_S_WRAP;
            ST_P_READ:   n_state = (r_count == '0) ? ST_F_ENTRY : ST_P_END;
            ST_P_END:    n_state = ST_P_CMP;
            ST_P_CMP:    n_state = alu_rsp.borrow ? ST_F_ENTRY : ST_P_READ;
            ST_A_TAIL:   n_state = ST_S_WRAP;
            ST_T_ADD:    n_state = r_tact ? ST_T_CMP : ST_S_WRAP;
            ST_T_CMP:    n_state = fire ? ST_T_WRAP : ST_S_WRAP;
            ST_T_WRAP:   n_state = ST_T_EMIT;
            ST_T_EMIT:   n_state = ofree ? ST_S_WRAP : ST_T_EMIT;
            ST_E_WRAP:   n_state = ST_E_EMIT;
            ST_E_EMIT:   n_state = ofree ? ST_S_WRAP : ST_E_EMIT;
            ST_S_WRAP:   n_state = ST_STATUS;
            ST_STATUS:   n_state = ofree ? ST_IDLE : ST_STATUS;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_next = r_next;   n_acked = r_acked; n_wnd = r_wnd;   n_flight = r_flight;
        n_syn = r_syn;     n_fin = r_fin;     n_tact = r_tact; n_tms = r_tms;
        n_cur = r_cur;     n_retry = r_retry; n_head = r_head; n_count = r_count;
        n_nseg = r_nseg;
        n_open = r_open;   n_ended = r_ended; n_ack = r_ack;
        n_pwin = r_pwin;   n_elap = r_elap;   n_buf = r_buf;
        n_abs = r_abs;     n_tmp = r_tmp;     n_dec = r_dec;   n_inc = r_inc;
        n_seq = r_seq;     n_slen = r_slen;   n_sflg = r_sflg;
        n_stop = r_stop;   n_from_ack = r_from_ack; n_first = r_first;
        n_accept = r_accept;
        n_ov = r_ov && !o_out.ready;
        n_o = r_o;
        wr_en = 1'b0;
        wr_addr = slot;
        wr_data = '{start: r_next, len: r_slen, flags: r_sflg};
        rd_en = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_open = i_in.open_request && (t_func'(i_in.func) == FN_FILL);
                    n_ack = i_in.ack_number;
                    n_pwin = i_in.peer_window;
                    n_elap = i_in.elapsed_ms;
                    n_buf = i_in.bytes_buffered;
                    n_ended = i_in.input_ended;
                    n_nseg = '0;
                    n_accept = 1'b1;
                    n_first = 1'b1;
                    n_from_ack = (t_func'(i_in.func) == FN_ACK);
                end
            end
            ST_F_ENTRY: begin
                // SYN goes out alone; the fill ends after it
                if (!r_fin && !r_syn && r_open && can_send) begin
                    n_syn = 1'b1;
                    n_slen = 11'd0;
                    n_sflg = 2'b01;
                    n_stop = 1'b1;
                end
            end
            ST_F_DIFF: begin
                n_tmp = alu_rsp.sum;
            end
            ST_F_DEC: begin
                n_first = 1'b0;
                if (fin_case) begin
                    if (can_send) begin
                        n_fin = 1'b1;
                        n_slen = 11'd0;
                        n_sflg = 2'b10;
                        n_stop = 1'b1;
                    end
                end else if (data_ok) begin
                    n_slen = take;
                    n_sflg = dfin ? 2'b10 : 2'b00;
                    n_buf = buf_left;
                    n_stop = dfin;
                    if (dfin) begin
                        n_fin = 1'b1;
                    end
                end
            end
            ST_SEND_WRAP, ST_E_WRAP, ST_S_WRAP, ST_T_WRAP: begin
                n_seq = alu_rsp.sum[31:0];
            end
            ST_SEND_EMIT: begin
                if (ofree) begin
                    wr_en = 1'b1;
                    n_flight = (flight_add > {1'b0, FLIGHT_MAX}) ? FLIGHT_MAX :
                               flight_add[16:0];
                    n_count = r_count + 1'b1;
                    n_nseg = r_nseg + 5'd1;
                    n_next = alu_rsp.sum;
                    if (!r_tact) begin
                        n_tact = 1'b1;
                        n_tms = 32'd0;
                    end
                    n_ov = 1'b1;
                    n_o = '{kind: KD_NEW, seqno: r_seq, len: r_slen, syn: r_sflg[0],
                            fin: r_sflg[1], acc: 1'b0, flight: n_flight,
                            retry: r_retry, last: 1'b0};
                end
            end
            ST_A_OFF: begin
                n_abs = {r_acked[63:32], alu_rsp.sum[31:0]};
            end
            ST_A_UNWRAP: begin
                // candidate shares the checkpoint's upper half, so the low word decides
                n_dec = ack_gt && alu_rsp.sum[31] && (alu_rsp.sum[30:0] != '0) &&
                        (r_abs[63:32] != 32'd0);
                n_inc = alu_rsp.borrow && !alu_rsp.sum[31] &&
                        (r_abs[63:32] != 32'hFFFF_FFFF);
            end
            ST_A_ADJ: begin
                if (r_dec || r_inc) begin
                    n_abs = alu_rsp.sum;
                end
            end
            ST_A_RANGE: begin
                if (alu_rsp.borrow) begin
                    n_accept = 1'b0;
                end else begin
                    n_wnd = r_pwin;
                end
            end
            ST_A_NEW: begin
                if (ack_gt) begin
                    n_acked = r_abs;
                end
            end
            ST_P_READ: begin
                if (r_count != '0) begin
                    rd_en = 1'b1;
                end else begin
                    n_first = 1'b1;
                end
            end
            ST_P_END: begin
                n_tmp = alu_rsp.sum;
            end
            ST_P_CMP: begin
                if (alu_rsp.borrow) begin
                    n_first = 1'b1;
                end else begin
                    n_head = head_inc;
                    n_count = r_count - 1'b1;
                    n_flight = ({5'd0, q_seqlen} < r_flight) ?
                               r_flight - {5'd0, q_seqlen} : 17'd0;
                end
            end
            ST_A_TAIL: begin
                n_cur = {16'd0, r_ito};
                n_retry = 8'd0;
                if (r_count != '0) begin
                    n_tact = 1'b1;
                    n_tms = 32'd0;
                end
            end
            ST_T_ADD: begin
                if (r_tact) begin
                    n_tms = alu_rsp.sum[32] ? 32'hFFFF_FFFF : alu_rsp.sum[31:0];
                end
            end
            ST_T_CMP: begin
                if (fire) begin
                    rd_en = 1'b1;
                    n_tms = 32'd0;
                    if (r_retry != 8'hFF) begin
                        n_retry = r_retry + 8'd1;
                    end
                    n_cur = r_cur[31] ? 32'hFFFF_FFFF : {r_cur[30:0], 1'b0};
                end
                if (r_count == '0) begin
                    n_tact = 1'b0;
                end
            end
            ST_T_EMIT: begin
                if (ofree) begin
                    n_ov = 1'b1;
                    n_o = '{kind: KD_RETX, seqno: r_seq, len: q_rd.len,
                            syn: q_rd.flags[0], fin: q_rd.flags[1], acc: 1'b0,
                            flight: r_flight, retry: r_retry, last: 1'b0};
                end
            end
            ST_E_EMIT: begin
                if (ofree) begin
                    n_ov = 1'b1;
                    n_o = '{kind: KD_EMPTY, seqno: r_seq, len: 11'd0, syn: 1'b0,
                            fin: 1'b0, acc: 1'b0, flight: r_flight,
                            retry: r_retry, last: 1'b0};
                end
            end
            ST_STATUS: begin
                if (ofree) begin
                    n_ov = 1'b1;
                    n_o = '{kind: KD_STATUS, seqno: r_seq, len: 11'd0, syn: 1'b0,
                            fin: 1'b0, acc: r_accept, flight: r_flight,
                            retry: r_retry, last: 1'b1};
                end
            end
            default: begin
                n_ov = r_ov && !o_out.ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_isn <= ISN_RST;
            r_ito <= ITO_RST;
            r_mss <= MSS_RST;
            r_next <= '0;
            r_acked <= '0;
            r_wnd <= '0;
            r_flight <= '0;
            r_syn <= 1'b0;
            r_fin <= 1'b0;
            r_tact <= 1'b0;
            r_tms <= '0;
            r_cur <= {16'd0, ITO_RST};
            r_retry <= '0;
            r_head <= '0;
            r_count <= '0;
            r_nseg <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.addr))
                    CFG_ISN: r_isn <= i_cfg.data;
                    CFG_ITO: r_ito <= i_cfg.data[15:0];
                    CFG_MSS: r_mss <= i_cfg.data[10:0];
                    default: r_isn <= r_isn;
                endcase
            end
            r_next <= n_next;
            r_acked <= n_acked;
            r_wnd <= n_wnd;
            r_flight <= n_flight;
            r_syn <= n_syn;
            r_fin <= n_fin;
            r_tact <= n_tact;
            r_tms <= n_tms;
            r_cur <= n_cur;
            r_retry <= n_retry;
            r_head <= n_head;
            r_count <= n_count;
            r_nseg <= n_nseg;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_open <= n_open;
        r_ended <= n_ended;
        r_ack <= n_ack;
        r_pwin <= n_pwin;
        r_elap <= n_elap;
        r_buf <= n_buf;
        r_abs <= n_abs;
        r_tmp <= n_tmp;
        r_dec <= n_dec;
        r_inc <= n_inc;
        r_seq <= n_seq;
        r_slen <= n_slen;
        r_sflg <= n_sflg;
        r_stop <= n_stop;
        r_from_ack <= n_from_ack;
        r_first <= n_first;
        r_accept <= n_accept;
        r_o <= n_o;
    end

    assign o_out.valid          = r_ov;
    assign o_out.kind           = r_o.kind;
    assign o_out.segment_seqno  = r_o.seqno;
    assign o_out.payload_length = r_o.len;
    assign o_out.syn_flag       = r_o.syn;
    assign o_out.fin_flag       = r_o.fin;
    assign o_out.ack_accepted   = r_o.acc;
    assign o_out.in_flight      = r_o.flight;
    assign o_out.retry_count    = r_o.retry;
    assign o_out.last_item      = r_o.last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("descriptor count above queue depth");

    a_nseg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nseg <= 5'(MAX_SEGS))
        else $error("too many segments for one request");

    a_ack_le_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acked <= r_next)
        else $error("acknowledged point ran past next sequence number");

    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STATUS && ofree) |=> (r_state == ST_IDLE && r_ov && r_o.last))
        else $error("status item did not close the request");

    a_send_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEND_EMIT && ofree) |-> (r_count < CW'(QUEUE_DEPTH)))
        else $error("segment queued into a full ring");
endmodule
